// ----- sv/two_key_sorted_insert_list_assert.svh -----
`ifndef TWO_KEY_SORTED_INSERT_LIST_ASSERT_SVH
`define TWO_KEY_SORTED_INSERT_LIST_ASSERT_SVH

// same-cycle implication, off while reset is high
`define TKSIL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tksil: same-cycle check failed");

// next-cycle implication, off while reset is high
`define TKSIL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tksil: next-cycle check failed");

`endif

// ----- sv/tksil_pkg.sv -----
`timescale 1ns / 1ps

package tksil_pkg;

  localparam int RANK_W   = 2;
  localparam int SALARY_W = 32;
  localparam int TAG_W    = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DUMP   = 1'b1
  } op_t;

  typedef struct packed {
    logic [RANK_W-1:0]   rank;
    logic [SALARY_W-1:0] salary;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  typedef struct packed {
    op_t    op;
    entry_t entry;
  } req_t;

endpackage

// ----- sv/two_key_sorted_insert_list.sv -----
`timescale 1ns / 1ps

// Sorted insertion list ordered by rank code ascending, then salary descending;
// a new entry goes ahead of older entries with equal keys. Requests are taken
// when start is high and busy is low; cmd 0 inserts, cmd 1 dumps the list.
// The front end queues up to two requests and drops busy while the queue has
// room. The back end finishes an insert at the edge that pops it (every cell
// compares itself with the new entry in parallel and the row shifts behind the
// insert point). A dump holds the back end after it takes the request until it
// has streamed one result per stored entry, one per cycle, the list rotating
// through cell 0; a dump of an empty list gives one result with out_valid low.
// Results come with strobe high for exactly one cycle and cannot be held off:
// the receiver must take them as they come. last marks the final result of a
// dump. An insert into a full list is dropped and sets overflow_seen, which
// stays high until reset. Inserts give no result. The first dump result is
// registered and comes only after the request has left the queue.
module two_key_sorted_insert_list #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cmd,
  input  logic [tksil_pkg::RANK_W-1:0]    title_rank,
  input  logic [tksil_pkg::SALARY_W-1:0]  salary_cents,
  input  logic [tksil_pkg::TAG_W-1:0]     employee_tag,
  output logic                            strobe,
  output logic                            out_valid,
  output logic [tksil_pkg::RANK_W-1:0]    out_rank,
  output logic [tksil_pkg::SALARY_W-1:0]  out_salary,
  output logic [tksil_pkg::TAG_W-1:0]     out_tag,
  output logic                            overflow_seen,
  output logic                            last
);
  import tksil_pkg::*;

  // request queue handshake between the two halves
  logic req_valid;
  req_t req;
  logic pop;

  // front end: accept and classify, buffer requests
  tksil_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .title_rank   (title_rank),
    .salary_cents (salary_cents),
    .employee_tag (employee_tag),
    .req_valid    (req_valid),
    .req          (req),
    .pop          (pop)
  );

  // back end: cell row, count, overflow flag and dump sequencer
  tksil_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req           (req),
    .pop           (pop),
    .strobe        (strobe),
    .out_valid     (out_valid),
    .out_rank      (out_rank),
    .out_salary    (out_salary),
    .out_tag       (out_tag),
    .overflow_seen (overflow_seen),
    .last          (last)
  );

endmodule

// ----- sv/tksil_front.sv -----
`timescale 1ns / 1ps

module tksil_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd,
  input  logic [tksil_pkg::RANK_W-1:0]        title_rank,
  input  logic [tksil_pkg::SALARY_W-1:0]      salary_cents,
  input  logic [tksil_pkg::TAG_W-1:0]         employee_tag,
  output logic                                req_valid,
  output tksil_pkg::req_t                     req,
  input  logic                                pop
);
  import tksil_pkg::*;

  // two-entry request queue
  req_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  req_t       incoming;

  // classify the request
  always_comb begin
    incoming.op           = op_t'(cmd);
    incoming.entry.rank   = title_rank;
    incoming.entry.salary = salary_cents;
    incoming.entry.tag    = employee_tag;
  end

  assign busy      = (fill == 2'd2);
  assign push      = start && !busy;
  assign req_valid = (fill != 2'd0);
  assign req       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= incoming;
  end

endmodule

// ----- sv/tksil_back.sv -----
`timescale 1ns / 1ps

module tksil_back #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  tksil_pkg::req_t                 req,
  output logic                            pop,
  output logic                            strobe,
  output logic                            out_valid,
  output logic [tksil_pkg::RANK_W-1:0]    out_rank,
  output logic [tksil_pkg::SALARY_W-1:0]  out_salary,
  output logic [tksil_pkg::TAG_W-1:0]     out_tag,
  output logic                            overflow_seen,
  output logic                            last
);
  import tksil_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t          state;
  entry_t          cells [DEPTH];
  logic [CW-1:0]   count;
  logic [CW-1:0]   remaining;
  logic            flag;
  logic [DEPTH-1:0] ahead;
  logic            full;
  logic            do_insert;
  logic            do_rotate;
  logic [CW-1:0]   tail;

  assign pop       = (state == ST_RUN) && req_valid;
  assign full      = (count == CW'(DEPTH));
  assign do_insert = pop && (req.op == OP_INSERT) && !full;
  assign do_rotate = (state == ST_DUMP);
  assign tail      = count - CW'(1);
  assign overflow_seen = flag;

  // cell row: each cell compares itself with the new entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ahead[i] = (CW'(i) < count) &&
                      ((cells[i].rank < req.entry.rank) ||
                       ((cells[i].rank == req.entry.rank) &&
                        (req.entry.salary < cells[i].salary)));

    always_ff @(posedge clk) begin
      if (do_insert) begin
        if (!ahead[i]) begin
          if (i == 0) cells[i] <= req.entry;
          else if (ahead[(i == 0) ? 0 : i-1]) cells[i] <= req.entry;
          else cells[i] <= cells[(i == 0) ? 0 : i-1];
        end
      end else if (do_rotate) begin
        // dump rotates the stored part: head goes to the tail slot
        if (CW'(i) == tail) cells[i] <= cells[0];
        else cells[i] <= cells[(i == DEPTH-1) ? i : i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      count     <= '0;
      remaining <= '0;
      flag      <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_RUN: begin
          if (pop) begin
            if (req.op == OP_INSERT) begin
              if (full) flag <= 1'b1;
              else count <= count + CW'(1);
            end else if (count == '0) begin
              strobe <= 1'b1;
            end else begin
              state     <= ST_DUMP;
              remaining <= count;
            end
          end
        end
        ST_DUMP: begin
          strobe    <= 1'b1;
          remaining <= remaining - CW'(1);
          if (remaining == CW'(1)) state <= ST_RUN;
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_DUMP) begin
      out_valid  <= 1'b1;
      out_rank   <= cells[0].rank;
      out_salary <= cells[0].salary;
      out_tag    <= cells[0].tag;
      last       <= (remaining == CW'(1));
    end else begin
      out_valid  <= 1'b0;
      out_rank   <= '0;
      out_salary <= '0;
      out_tag    <= '0;
      last       <= 1'b1;
    end
  end

endmodule

// ----- sv/tksil_checker.sv -----
`timescale 1ns / 1ps

`include "two_key_sorted_insert_list_assert.svh"

module tksil_checker (
  input logic clk,
  input logic rst,
  input logic strobe,
  input logic out_valid,
  input logic overflow_seen,
  input logic last
);

  // an empty-list result is always the only result of its dump
  `TKSIL_ASSERT_NOW(a_empty_is_last, clk, rst, strobe && !out_valid, last)

  // a dump streams without gaps until its last result
  `TKSIL_ASSERT_NEXT(a_dump_no_gap, clk, rst, strobe && !last, strobe)

  // entries after the first of a dump are valid entries
  `TKSIL_ASSERT_NEXT(a_dump_stays_valid, clk, rst, strobe && !last, out_valid)

  // overflow flag never clears outside reset
  `TKSIL_ASSERT_NEXT(a_overflow_sticky, clk, rst, overflow_seen, overflow_seen)

endmodule

bind two_key_sorted_insert_list tksil_checker u_tksil_checker (
  .clk           (clk),
  .rst           (rst),
  .strobe        (strobe),
  .out_valid     (out_valid),
  .overflow_seen (overflow_seen),
  .last          (last)
);

// ----- tb/two_key_sorted_insert_list_checker.sv -----
`timescale 1ns / 1ps

module two_key_sorted_insert_list_checker #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            cmd,
  input  logic [tksil_pkg::RANK_W-1:0]    title_rank,
  input  logic [tksil_pkg::SALARY_W-1:0]  salary_cents,
  input  logic [tksil_pkg::TAG_W-1:0]     employee_tag,
  input  logic                            strobe,
  input  logic                            out_valid,
  input  logic [tksil_pkg::RANK_W-1:0]    out_rank,
  input  logic [tksil_pkg::SALARY_W-1:0]  out_salary,
  input  logic [tksil_pkg::TAG_W-1:0]     out_tag,
  input  logic                            overflow_seen,
  input  logic                            last,
  output int                              mismatches,
  output int                              outstanding
);

  typedef struct packed {
    logic              valid;
    tksil_pkg::entry_t entry;
    logic              ovf;
    logic              last;
  } report_t;

  localparam int SHOWN_MISMATCHES = 10;

  // ordered copy of the list, rank ascending then salary descending
  tksil_pkg::entry_t list_rows [DEPTH];
  int                row_count;
  logic              overflow_sticky;
  report_t           awaited_reports [$];
  int                fail_total;

  initial begin
    row_count       = 0;
    overflow_sticky = 1'b0;
    fail_total      = 0;
  end

  function automatic void insert_row(tksil_pkg::entry_t e);
    int pos;
    int i;
    if (row_count >= DEPTH) begin
      overflow_sticky = 1'b1;
      return;
    end
    pos = 0;
    // older rows stay ahead while strictly better on the two keys
    while (pos < row_count && (list_rows[pos].rank < e.rank ||
           (list_rows[pos].rank == e.rank && e.salary < list_rows[pos].salary)))
      pos++;
    for (i = row_count; i > pos; i--)
      list_rows[i] = list_rows[i-1];
    list_rows[pos] = e;
    row_count++;
  endfunction

  function automatic void queue_dump();
    report_t r;
    int i;
    if (row_count == 0) begin
      r      = '0;
      r.ovf  = overflow_sticky;
      r.last = 1'b1;
      awaited_reports.push_back(r);
      return;
    end
    for (i = 0; i < row_count; i++) begin
      r.valid = 1'b1;
      r.entry = list_rows[i];
      r.ovf   = overflow_sticky;
      r.last  = (i == row_count - 1);
      awaited_reports.push_back(r);
    end
  endfunction

  function automatic void note_mismatch(string what, report_t want, report_t seen);
    fail_total++;
    if (fail_total <= SHOWN_MISMATCHES)
      $display("%0t: %s: expected v%0b r%0d s%08h t%04h o%0b l%0b,",
               $realtime, what,
               want.valid, want.entry.rank, want.entry.salary, want.entry.tag,
               want.ovf, want.last,
               " got v%0b r%0d s%08h t%04h o%0b l%0b",
               seen.valid, seen.entry.rank, seen.entry.salary, seen.entry.tag,
               seen.ovf, seen.last);
  endfunction

  always @(posedge clk) begin
    report_t           seen;
    report_t           want;
    tksil_pkg::entry_t incoming;
    if (!rst) begin
      // results first: a request taken at this edge cannot answer at it
      if (strobe) begin
        seen.valid        = out_valid;
        seen.entry.rank   = out_rank;
        seen.entry.salary = out_salary;
        seen.entry.tag    = out_tag;
        seen.ovf          = overflow_seen;
        seen.last         = last;
        if (awaited_reports.size() == 0) begin
          note_mismatch("result with nothing awaited", '0, seen);
        end else begin
          want = awaited_reports.pop_front();
          if (seen.valid !== want.valid || seen.entry.rank !== want.entry.rank ||
              seen.entry.salary !== want.entry.salary ||
              seen.entry.tag !== want.entry.tag ||
              seen.ovf !== want.ovf || seen.last !== want.last)
            note_mismatch("wrong result", want, seen);
        end
      end
      if (start && !busy) begin
        if (tksil_pkg::op_t'(cmd) == tksil_pkg::OP_DUMP) begin
          queue_dump();
        end else begin
          incoming.rank   = title_rank;
          incoming.salary = salary_cents;
          incoming.tag    = employee_tag;
          insert_row(incoming);
        end
      end
    end
    mismatches  <= fail_total;
    outstanding <= awaited_reports.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  import tksil_pkg::*;

  localparam int LIST_DEPTH      = 16;
  localparam int RANDOM_REQUESTS = 418;
  // a full dump, one queued behind it, and some slack
  localparam int DRAIN_CYCLES    = 2 * LIST_DEPTH + 16;

  // title rank codes
  localparam logic [RANK_W-1:0] RANK_UNKNOWN    = 2'd0;
  localparam logic [RANK_W-1:0] RANK_MANAGER    = 2'd1;
  localparam logic [RANK_W-1:0] RANK_SUPERVISOR = 2'd2;
  localparam logic [RANK_W-1:0] RANK_WORKER     = 2'd3;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                cmd;
  logic [RANK_W-1:0]   title_rank;
  logic [SALARY_W-1:0] salary_cents;
  logic [TAG_W-1:0]    employee_tag;
  logic                strobe;
  logic                out_valid;
  logic [RANK_W-1:0]   out_rank;
  logic [SALARY_W-1:0] out_salary;
  logic [TAG_W-1:0]    out_tag;
  logic                overflow_seen;
  logic                last;
  int                  mismatches;
  int                  outstanding;

  two_key_sorted_insert_list #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .title_rank   (title_rank),
    .salary_cents (salary_cents),
    .employee_tag (employee_tag),
    .strobe       (strobe),
    .out_valid    (out_valid),
    .out_rank     (out_rank),
    .out_salary   (out_salary),
    .out_tag      (out_tag),
    .overflow_seen(overflow_seen),
    .last         (last)
  );

  // watches both sides, predicts the dumps and counts mismatches
  two_key_sorted_insert_list_checker #(
    .DEPTH(LIST_DEPTH)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .title_rank   (title_rank),
    .salary_cents (salary_cents),
    .employee_tag (employee_tag),
    .strobe       (strobe),
    .out_valid    (out_valid),
    .out_rank     (out_rank),
    .out_salary   (out_salary),
    .out_tag      (out_tag),
    .overflow_seen(overflow_seen),
    .last         (last),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

  // salaries drawn so that equal keys and the extremes come up often
  function automatic logic [SALARY_W-1:0] pick_salary();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(5))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h7FFF_FFFF;
          3:       return 32'h8000_0000;
          4:       return 32'd1000;
          default: return 32'd1001;
        endcase
      end
      1:       return 32'($urandom_range(1003, 1000));
      default: return $urandom;
    endcase
  endfunction

  // one request: hold start until taken, then maybe leave a gap
  task automatic send_request(input op_t op, input logic [RANK_W-1:0] rank,
                              input logic [SALARY_W-1:0] salary,
                              input logic [TAG_W-1:0] tag, input int idle_pct);
    int gap;
    start        <= 1'b1;
    cmd          <= op;
    title_rank   <= rank;
    salary_cents <= salary;
    employee_tag <= tag;
    // taken at the first edge that sees busy low
    do @(posedge clk); while (busy);
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    // start only drops when a gap follows, so it never toggles within a step
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int   idle_pct;
    op_t  op;
    start        <= 1'b0;
    cmd          <= OP_INSERT;
    title_rank   <= RANK_UNKNOWN;
    salary_cents <= '0;
    employee_tag <= '0;
    rst          <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty dump, key extremes, tie order, every rank code
    send_request(OP_DUMP,   RANK_WORKER,     32'hFFFF_FFFF, 16'hFFFF, 21);
    send_request(OP_INSERT, RANK_WORKER,     32'h0000_0000, 16'h0000, 21);
    send_request(OP_INSERT, RANK_UNKNOWN,    32'hFFFF_FFFF, 16'hFFFF, 21);
    send_request(OP_INSERT, RANK_MANAGER,    32'd1000,      16'h0001, 21);
    send_request(OP_INSERT, RANK_SUPERVISOR, 32'h8000_0000, 16'h0002, 21);
    send_request(OP_DUMP,   RANK_UNKNOWN,    32'h0000_0000, 16'h0000, 21);
    // same keys as an older row: the new one must land in front of it
    send_request(OP_INSERT, RANK_MANAGER,    32'd1000,      16'h0003, 21);
    send_request(OP_INSERT, RANK_MANAGER,    32'd999,       16'h0004, 21);
    send_request(OP_INSERT, RANK_MANAGER,    32'd1001,      16'h0005, 21);
    // unknown title ahead of every other rank, worker at the top salary
    send_request(OP_INSERT, RANK_UNKNOWN,    32'h0000_0000, 16'h0006, 21);
    send_request(OP_INSERT, RANK_WORKER,     32'hFFFF_FFFF, 16'h0007, 21);
    send_request(OP_DUMP,   RANK_SUPERVISOR, 32'h5555_5555, 16'hAAAA, 21);

    // random: the list fills with dumps between inserts, then refused
    // inserts and full dumps keep the overflow flag under test
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n < RANDOM_REQUESTS / 3)
        idle_pct = 21;
      else if (n < 2 * RANDOM_REQUESTS / 3)
        idle_pct = 59;
      else
        idle_pct = 0;
      op = ($urandom_range(99) < 35) ? OP_DUMP : OP_INSERT;
      send_request(op, RANK_W'($urandom_range(3)), pick_salary(),
                   TAG_W'($urandom_range(16'hFFFF)), idle_pct);
    end
    start <= 1'b0;

    // let the checker see the last request, then drain every dump row
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/tksil_pkg.sv
sv/tksil_front.sv
sv/tksil_back.sv
sv/two_key_sorted_insert_list.sv
sv/tksil_checker.sv
tb/two_key_sorted_insert_list_checker.sv
tb/tb_top.sv
